>>> rtl/core/bracket_balance_checker_defines.svh
// Assertion macros of the bracket balance checker, used by its back end.
`ifndef BRACKET_BALANCE_CHECKER_DEFINES_SVH
`define BRACKET_BALANCE_CHECKER_DEFINES_SVH

// Plain check, sampled on clk and switched off while rst_n is low.
`define BBC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("bracket_balance_checker: check failed");

// Implication checked from the cycle after the antecedent.
`define BBC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bracket_balance_checker: check failed");

`endif

>>> rtl/core/bbc_pkg.sv
// Shared types and constants of the bracket balance checker.
`default_nettype none

package bbc_pkg;

  // Default stack depth (number of open brackets that can be held).
  localparam int BBC_DEPTH = 64;

  // Entries in the queue between front and back; a power of two.
  localparam int QDEPTH = 2;

  // Width of the packed result on the output channel.
  localparam int OUT_W = 16;

  typedef logic [1:0] op_t;
  localparam op_t OP_NONE  = 2'd0;
  localparam op_t OP_OPEN  = 2'd1;
  localparam op_t OP_CLOSE = 2'd2;

  typedef logic [2:0] cause_t;
  localparam cause_t CAUSE_NONE     = 3'd0;
  localparam cause_t CAUSE_EMPTY    = 3'd1;
  localparam cause_t CAUSE_MISMATCH = 3'd2;
  localparam cause_t CAUSE_UNCLOSED = 3'd3;
  localparam cause_t CAUSE_OVERFLOW = 3'd4;

  typedef logic [1:0] kind_t;

  // One classified item as it travels from front to back.
  typedef struct packed {
    op_t   op;
    kind_t kind;
    logic  last;
  } item_t;

endpackage

`default_nettype wire

>>> rtl/core/bbc_front.sv
// Front end: accepts input items and classifies each byte as opener, closer or other.
`default_nettype none

module bbc_front (
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [7:0]   in_tdata,
  input  wire logic         in_tuser,
  input  wire logic         in_tlast,
  input  wire logic         q_full,
  output logic              q_push,
  output bbc_pkg::item_t    q_item
);
  import bbc_pkg::*;

  localparam logic [7:0] OPENERS [4] = '{8'h28, 8'h7B, 8'h5B, 8'h3C};
  localparam logic [7:0] CLOSERS [4] = '{8'h29, 8'h7D, 8'h5D, 8'h3E};

  logic  is_open;
  logic  is_close;
  kind_t open_kind;
  kind_t close_kind;

  always_comb begin
    is_open    = 1'b0;
    is_close   = 1'b0;
    open_kind  = 2'd0;
    close_kind = 2'd0;
    for (int k = 0; k < 4; k++) begin
      if (in_tdata == OPENERS[k]) begin
        is_open   = 1'b1;
        open_kind = kind_t'(k);
      end
      if (in_tdata == CLOSERS[k]) begin
        is_close   = 1'b1;
        close_kind = kind_t'(k);
      end
    end
  end

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  always_comb begin
    q_item.last = in_tlast;
    q_item.kind = is_open ? open_kind : close_kind;
    if (in_tuser && is_open) begin
      q_item.op = OP_OPEN;
    end else if (in_tuser && is_close) begin
      q_item.op = OP_CLOSE;
    end else begin
      q_item.op = OP_NONE;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/bbc_queue.sv
// Short first-in first-out queue of classified items between front and back.
`default_nettype none

module bbc_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire bbc_pkg::item_t  push_item,
  output logic                 full,
  output logic                 pop_valid,
  output bbc_pkg::item_t       pop_item,
  input  wire logic            pop
);
  import bbc_pkg::*;

  localparam int QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCW = $clog2(QDEPTH + 1);

  item_t            slots_r [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r;
  logic [QAW-1:0]   wr_ptr_nxt;
  logic [QAW-1:0]   rd_ptr_r;
  logic [QAW-1:0]   rd_ptr_nxt;
  logic [QCW-1:0]   fill_r;
  logic [QCW-1:0]   fill_nxt;

  assign full      = (fill_r == QCW'(QDEPTH));
  assign pop_valid = (fill_r != '0);
  assign pop_item  = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? QAW'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? QAW'(rd_ptr_r + 1'b1) : rd_ptr_r;
    fill_nxt   = fill_r;
    if (push && !pop) begin
      fill_nxt = QCW'(fill_r + 1'b1);
    end else if (pop && !push) begin
      fill_nxt = QCW'(fill_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/bbc_back.sv
// Back end: bracket stack, sticky error and the registered result of each text.
`default_nettype none

module bbc_back #(
  parameter int DEPTH = bbc_pkg::BBC_DEPTH
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       q_valid,
  input  wire bbc_pkg::item_t             q_item,
  output logic                            q_take,
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  output logic [bbc_pkg::OUT_W-1:0]       out_tdata
);
  import bbc_pkg::*;
  `include "bracket_balance_checker_defines.svh"

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  kind_t              stack_mem [DEPTH];
  logic [CW-1:0]      count_r;
  logic [CW-1:0]      count_nxt;
  logic [CW-1:0]      count_now;
  cause_t             err_r;
  cause_t             err_nxt;
  cause_t             err_now;
  kind_t              top_r;
  kind_t              top_nxt;
  kind_t              second_r;
  logic               out_valid_r;
  logic               out_valid_nxt;
  logic [OUT_W-1:0]   out_data_r;

  logic               active;
  logic               full;
  logic               do_push;
  logic               do_pop;
  logic               end_text;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  cause_t             res_cause;
  logic [6:0]         res_depth;

  // An end-of-text item needs the output register; other items never wait.
  assign q_take   = q_valid && (!q_item.last || !out_valid_r || out_tready);
  assign active   = q_take && (err_r == CAUSE_NONE);
  assign end_text = q_take && q_item.last;
  assign full     = (32'(count_r) >= DEPTH);
  assign do_push  = active && (q_item.op == OP_OPEN) && !full;
  assign do_pop   = active && (q_item.op == OP_CLOSE) && (count_r != '0) &&
                    (top_r == q_item.kind);

  always_comb begin
    err_now = err_r;
    if (active && (q_item.op == OP_OPEN) && full) begin
      err_now = CAUSE_OVERFLOW;
    end else if (active && (q_item.op == OP_CLOSE) && (count_r == '0)) begin
      err_now = CAUSE_EMPTY;
    end else if (active && (q_item.op == OP_CLOSE) && (top_r != q_item.kind)) begin
      err_now = CAUSE_MISMATCH;
    end

    count_now = count_r;
    if (do_push) begin
      count_now = CW'(count_r + 1'b1);
    end else if (do_pop) begin
      count_now = CW'(count_r - 1'b1);
    end

    if (err_now != CAUSE_NONE) begin
      res_cause = err_now;
    end else if (count_now != '0) begin
      res_cause = CAUSE_UNCLOSED;
    end else begin
      res_cause = CAUSE_NONE;
    end
    res_depth = (32'(count_now) > 32'd127) ? 7'd127 : 7'(count_now);

    count_nxt = end_text ? '0 : count_now;
    err_nxt   = end_text ? CAUSE_NONE : err_now;

    if (do_push) begin
      top_nxt = q_item.kind;
    end else if (do_pop) begin
      top_nxt = second_r;
    end else begin
      top_nxt = top_r;
    end

    // Prefetch the entry just below the new top.
    rd_en   = (32'(count_nxt) >= 32'd2);
    rd_addr = AW'(32'(count_nxt) - 32'd2);

    if (end_text) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      err_r       <= CAUSE_NONE;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r <= top_nxt;
    if (end_text) begin
      out_data_r <= OUT_W'({res_depth, res_cause, (res_cause == CAUSE_NONE)});
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      stack_mem[count_r[AW-1:0]] <= q_item.kind;
    end
    if (rd_en) begin
      second_r <= stack_mem[rd_addr];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `BBC_ASSERT(a_count_bound, 32'(count_r) <= DEPTH)
  `BBC_ASSERT_NEXT(a_clear_after_end, end_text, (count_r == '0) && (err_r == CAUSE_NONE))
  `BBC_ASSERT_NEXT(a_frozen_stack, (err_r != CAUSE_NONE) && !end_text, $stable(count_r))
  `BBC_ASSERT_NEXT(a_sticky_error, (err_r != CAUSE_NONE) && !end_text, $stable(err_r))
  `BBC_ASSERT(a_result_held, (out_valid_r && !out_tready) |-> !end_text)

endmodule

`default_nettype wire

>>> rtl/core/bracket_balance_checker.sv
// Top level of the bracket balance checker.
`default_nettype none

// Checks that the brackets ( { [ < and their closers ) } ] > nest correctly
// in a text that arrives one byte per item; all other bytes are ignored.
// Each opener is pushed onto a stack of DEPTH entries and each closer must
// match the kind on top. The first error is kept (closer on an empty stack,
// kind mismatch, or an opener met with a full stack) and the rest of that
// text is then ignored, the stack frozen at that moment. The item with
// in_tlast high ends the text: after its byte, if it carries one, one result
// item gives the verdict, the first error cause (unclosed openers if there
// was no other error but the stack is not empty) and the depth still open,
// saturated at 127. The state then clears for the next text.
// The block takes one item every clock cycle while in_tready is high. The
// top of the stack is held in a register, the entry below it is prefetched
// by a registered read, so push, pop and compare never wait on the memory.
// out_tvalid rises at the clock edge at which the stack logic takes the last
// item of a text from the queue, where it may first wait behind a result.
// The result then waits in an output register. A two-item queue between
// the classifying front end and the stack logic lets input keep flowing
// while a result waits, until the next end-of-text item reaches the stack
// logic; from then on the queue fills and in_tready drops until the waiting
// result is taken.
// The stack memory needs no clearing pass after reset, as only entries that
// have been written are ever read.

module bracket_balance_checker #(
  parameter int DEPTH = bbc_pkg::BBC_DEPTH
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  input  wire logic [7:0]                 in_tdata,   // [7:0] ch
  input  wire logic                       in_tuser,   // [0] char_valid
  input  wire logic                       in_tlast,
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  output logic [bbc_pkg::OUT_W-1:0]       out_tdata   // [0] balanced, [3:1] error_cause,
                                                      // [10:4] open_depth, [15:11] zero
);
  import bbc_pkg::*;

  logic  q_full;
  logic  q_push;
  item_t q_push_item;
  logic  q_valid;
  item_t q_item;
  logic  q_take;

  bbc_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (q_push_item)
  );

  bbc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_push_item),
    .full      (q_full),
    .pop_valid (q_valid),
    .pop_item  (q_item),
    .pop       (q_take)
  );

  bbc_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_take     (q_take),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire
